FILE: rtl/rgbypb_pkg.sv
package rgbypb_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned OUT_W    = 16;

	localparam logic [SAMPLE_W-1:0] MAX_SAMPLE_RESET = 16'd255;

	localparam int unsigned MU_Y_R = 299000;
	localparam int unsigned MU_Y_G = 587000;
	localparam int unsigned MU_Y_B = 114000;
	localparam int unsigned MU_B_R = 168736;
	localparam int unsigned MU_B_G = 331264;
	localparam int unsigned MU_B_B = 500000;
	localparam int unsigned MU_R_R = 500000;
	localparam int unsigned MU_R_G = 418688;
	localparam int unsigned MU_R_B = 81312;

	localparam int unsigned Q_W          = 17;
	localparam int unsigned DIV_W        = SAMPLE_W + Q_W;
	localparam int unsigned DIV_STEPS    = Q_W;
	localparam int unsigned FRONT_STAGES = 5;
	localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + DIV_STEPS + 1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic        [OUT_W-1:0] luma;
		logic signed [OUT_W-1:0] chroma_blue;
		logic signed [OUT_W-1:0] chroma_red;
	} res_t;

endpackage

FILE: rtl/rgb_to_ypbpr_converter_top.sv
// BT.601 RGB to YPbPr converter. Takes one pixel per clock while the output is not stalled
// and returns Y in unsigned Q0.16 and Pb, Pr in signed Q0.16, each rounded to nearest and
// saturated. Samples above max_sample are clamped to it, and a max_sample of zero acts as
// one. The scaling by 1/max_sample runs as a restoring divider of 17 pipeline stages per
// channel, one quotient bit per stage, behind clamp, multiply, sum, magnitude and
// rounding-bias stages; every stage takes a new pixel each cycle, so the sustained rate is
// one pixel per clock unless stalled. A stalled output only holds the stages that are full,
// so empty stages keep filling. Write max_sample only while no pixel is in flight.
module rgb_to_ypbpr_converter_top #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pix_valid,
	output logic                                  pix_stall,
	input  rgbypb_pkg::pix_t                      pix,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output rgbypb_pkg::res_t                      res,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rgbypb_pkg::SAMPLE_W-1:0]       cfg_data
);

	localparam int unsigned SMW  = rgbypb_pkg::SAMPLE_W;
	localparam int unsigned CW   = FRAC_BITS;
	localparam int unsigned PW   = CW + SMW;
	localparam int unsigned SW   = PW + 2;
	localparam int unsigned MW   = SW - 1;
	localparam int unsigned NW   = MW + rgbypb_pkg::OUT_W + 1;
	localparam int unsigned DW   = rgbypb_pkg::DIV_W;
	localparam int unsigned QW   = rgbypb_pkg::Q_W;
	localparam int unsigned DS   = rgbypb_pkg::DIV_STEPS;
	localparam int unsigned DIV0 = rgbypb_pkg::FRONT_STAGES;
	localparam int unsigned NST  = rgbypb_pkg::PIPE_DEPTH;

	localparam logic [CW-1:0] C_YR =
		CW'(((64'(rgbypb_pkg::MU_Y_R) << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_YG =
		CW'(((64'(rgbypb_pkg::MU_Y_G) << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_YB =
		CW'(((64'(rgbypb_pkg::MU_Y_B) << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_BR =
		CW'(((64'(rgbypb_pkg::MU_B_R) << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_BG =
		CW'(((64'(rgbypb_pkg::MU_B_G) << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_BB =
		CW'(((64'(rgbypb_pkg::MU_B_B) << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_RR =
		CW'(((64'(rgbypb_pkg::MU_R_R) << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_RG =
		CW'(((64'(rgbypb_pkg::MU_R_G) << FRAC_BITS) + 64'd500000) / 64'd1000000);
	localparam logic [CW-1:0] C_RB =
		CW'(((64'(rgbypb_pkg::MU_R_B) << FRAC_BITS) + 64'd500000) / 64'd1000000);

	localparam logic [CW-1:0] COEF [3][3] = '{
		'{C_YR, C_YG, C_YB},
		'{C_BR, C_BG, C_BB},
		'{C_RR, C_RG, C_RB}
	};

	logic [SMW-1:0]   dmax_q;
	logic [NST-1:0]   vld_q;
	logic [NST-1:0]   load;

	logic [SMW-1:0]   samp_s1 [3];
	logic [PW-1:0]    prod_s2 [3][3];
	logic [SW-1:0]    sum_s3  [3];
	logic [MW-1:0]    mag_s4  [3];
	logic [2:0]       neg_s4;
	logic [NW-1:0]    bias_num [3];
	logic [DW-1:0]    num_s5  [3];
	logic [2:0]       neg_s5;
	logic [DW-1:0]    work_sd [DS][3];
	logic [2:0]       neg_sd  [DS];
	logic [QW-1:0]    quo     [3];
	rgbypb_pkg::res_t res_d;
	rgbypb_pkg::res_t res_so;

	function automatic logic [DW-1:0] div_step(input logic [DW-1:0] w,
			input logic [SMW-1:0] d);
		logic [DW:0]    sh;
		logic [SMW:0]   hi;
		logic [SMW:0]   diff;
		sh   = {w, 1'b0};
		hi   = sh[DW:DW-SMW];
		diff = hi - {1'b0, d};
		if (hi >= {1'b0, d}) begin
			div_step = {diff[SMW-1:0], sh[DW-SMW-1:1], 1'b1};
		end else begin
			div_step = sh[DW-1:0];
		end
	endfunction

	function automatic logic [rgbypb_pkg::OUT_W-1:0] sat_signed(input logic neg,
			input logic [QW-1:0] q);
		if (neg) begin
			sat_signed = (q > 17'd32768) ? 16'h8000 : 16'(-q);
		end else begin
			sat_signed = (q > 17'd32767) ? 16'h7FFF : q[15:0];
		end
	endfunction

	// advance a stage when the output is not stalled or a stage at or ahead of it is empty
	for (genvar k = 0; k < NST; k++) begin : g_load
		assign load[k] = !res_stall || !(&vld_q[NST-1:k]);
	end

	assign pix_stall = !load[0];
	assign cfg_ready = 1'b1;
	assign res_valid = vld_q[NST-1];
	assign res       = res_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmax_q <= rgbypb_pkg::MAX_SAMPLE_RESET;
		end else if (cfg_valid) begin
			dmax_q <= (cfg_data == '0) ? SMW'(1) : cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0]) begin
				vld_q[0] <= pix_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (load[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			samp_s1[0] <= (pix.red   > dmax_q) ? dmax_q : pix.red;
			samp_s1[1] <= (pix.green > dmax_q) ? dmax_q : pix.green;
			samp_s1[2] <= (pix.blue  > dmax_q) ? dmax_q : pix.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			for (int c = 0; c < 3; c++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[c][j] <= PW'(COEF[c][j]) * PW'(samp_s1[j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			sum_s3[0] <= SW'(prod_s2[0][0]) + SW'(prod_s2[0][1]) + SW'(prod_s2[0][2]);
			sum_s3[1] <= SW'(prod_s2[1][2]) - SW'(prod_s2[1][0]) - SW'(prod_s2[1][1]);
			sum_s3[2] <= SW'(prod_s2[2][0]) - SW'(prod_s2[2][1]) - SW'(prod_s2[2][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (load[3]) begin
			for (int c = 0; c < 3; c++) begin
				neg_s4[c] <= sum_s3[c][SW-1];
				mag_s4[c] <= sum_s3[c][SW-1] ? MW'(-sum_s3[c]) : MW'(sum_s3[c]);
			end
		end
	end

	// add half the divisor, then drop the coefficient fraction
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			bias_num[c] = (NW'(mag_s4[c]) << rgbypb_pkg::OUT_W)
				+ (NW'(dmax_q) << (FRAC_BITS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (load[4]) begin
			for (int c = 0; c < 3; c++) begin
				num_s5[c] <= bias_num[c][FRAC_BITS +: DW];
			end
			neg_s5 <= neg_s4;
		end
	end

	for (genvar j = 0; j < DS; j++) begin : g_div
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (load[DIV0]) begin
					for (int c = 0; c < 3; c++) begin
						work_sd[0][c] <= div_step(num_s5[c], dmax_q);
					end
					neg_sd[0] <= neg_s5;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (load[DIV0+j]) begin
					for (int c = 0; c < 3; c++) begin
						work_sd[j][c] <= div_step(work_sd[j-1][c], dmax_q);
					end
					neg_sd[j] <= neg_sd[j-1];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quo[c] = work_sd[DS-1][c][QW-1:0];
		end
		if (neg_sd[DS-1][0]) begin
			res_d.luma = '0;
		end else begin
			res_d.luma = (quo[0] > 17'd65535) ? 16'hFFFF : quo[0][15:0];
		end
		res_d.chroma_blue = sat_signed(neg_sd[DS-1][1], quo[1]);
		res_d.chroma_red  = sat_signed(neg_sd[DS-1][2], quo[2]);
	end

	always_ff @(posedge clk) begin
		if (load[NST-1]) begin
			res_so <= res_d;
		end
	end

endmodule

FILE: rtl/rgbypb_checker.sv
module rgbypb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pix_valid,
	input logic             pix_stall,
	input logic             res_valid,
	input logic             res_stall,
	input rgbypb_pkg::res_t res
);

	localparam int unsigned CNTW = $clog2(rgbypb_pkg::PIPE_DEPTH + 1) + 1;

	logic            pix_xfer;
	logic            res_xfer;
	logic [CNTW-1:0] cnt_q;

	assign pix_xfer = pix_valid && !pix_stall;
	assign res_xfer = res_valid && !res_stall;

	// track pixels in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pix_xfer && !res_xfer) begin
			cnt_q <= cnt_q + CNTW'(1);
		end else if (res_xfer && !pix_xfer) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cnt_q != '0)
		else $error("result without a pixel in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(rgbypb_pkg::PIPE_DEPTH))
		else $error("more pixels in flight than pipeline stages");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("input stalled while output can drain");

endmodule

bind rgb_to_ypbpr_converter_top rgbypb_checker u_rgbypb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
